@@ src/dltq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared widths, constants, command codes and saturation helpers for the
// delta-list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int TIMERS     = 16;
  localparam int ID_BITS    = $clog2(TIMERS);
  localparam int PTR_BITS   = ID_BITS + 1;
  localparam int DELAY_BITS = 32;
  localparam int AMT_BITS   = 32;
  localparam int CD_BITS    = 40;
  localparam int REL_BITS   = CD_BITS + 1;
  localparam int SUM_BITS   = CD_BITS + 2;

  localparam logic [PTR_BITS-1:0]          NIL       = PTR_BITS'(TIMERS);
  localparam logic [DELAY_BITS-1:0]        DELAY_MAX = '1;
  localparam logic signed [CD_BITS-1:0]    CD_MAX    = {1'b0, {(CD_BITS-1){1'b1}}};
  localparam logic signed [CD_BITS-1:0]    CD_MIN    = {1'b1, {(CD_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0]   SUM_MAX   = SUM_BITS'(CD_MAX);
  localparam logic signed [SUM_BITS-1:0]   SUM_MIN   = SUM_BITS'(CD_MIN);
  localparam logic signed [CD_BITS-1:0]    NOT_QUEUED = '1;

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_QUERY    = 2'd1,
    CMD_FIRE     = 2'd2,
    CMD_ELAPSE   = 2'd3
  } cmd_t;

  function automatic logic signed [CD_BITS-1:0] clamp_cd(
    input logic signed [SUM_BITS-1:0] v
  );
    logic signed [CD_BITS-1:0] r;
    if (v > SUM_MAX) begin
      r = CD_MAX;
    end else if (v < SUM_MIN) begin
      r = CD_MIN;
    end else begin
      r = v[CD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [DELAY_BITS-1:0] clamp_delay(input logic [REL_BITS-1:0] v);
    logic [DELAY_BITS-1:0] r;
    if (v > REL_BITS'(DELAY_MAX)) begin
      r = DELAY_MAX;
    end else begin
      r = v[DELAY_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/dltq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output      logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/delta_list_timer_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Timer set kept as a sorted delta list in two RAMs, with a countdown to the
// head timer.
// ----------------------------------------------------------------------------
// One command is worked on at a time and each gives exactly one result.
// Elapse, a schedule of a timer already queued or into an empty list, and
// a fire on an empty list go straight to the result state; a schedule ahead
// of the head passes through a finish state, a fire through a link read
// and, unless the list is left empty, a delay read. A schedule further down
// the list and a query of a timer behind the head walk the list one entry at
// a time, since each step reads the link RAM and then the delay RAM through
// their single registered read ports. A new command is taken as soon as the
// previous result is in the output register, even while that result still
// waits to be taken.
// ----------------------------------------------------------------------------
module delta_list_timer_queue
  import dltq_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [1:0]                  command,
  input  wire logic [ID_BITS-1:0]          timer_id,
  input  wire logic [AMT_BITS-1:0]         amount,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [1:0]                  kind,
  output      logic                        fired,
  output      logic [ID_BITS-1:0]          fired_id,
  output      logic signed [CD_BITS-1:0]   remaining,
  output      logic                        due,
  output      logic signed [CD_BITS-1:0]   countdown_now
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_S_LINK = 9'b000000010,
    ST_S_DLY  = 9'b000000100,
    ST_S_FIN  = 9'b000001000,
    ST_Q_LINK = 9'b000010000,
    ST_Q_DLY  = 9'b000100000,
    ST_F_LINK = 9'b001000000,
    ST_F_DLY  = 9'b010000000,
    ST_RES    = 9'b100000000
  } state_t;

  state_t                      state, state_next;
  logic [TIMERS-1:0]           queued, queued_next;
  logic [PTR_BITS-1:0]         head_ptr, head_next;
  logic signed [CD_BITS-1:0]   countdown, countdown_next;

  logic [ID_BITS-1:0]          tid, tid_next;
  logic [PTR_BITS-1:0]         cur, cur_next;
  logic [PTR_BITS-1:0]         nx, nx_next;
  logic [REL_BITS-1:0]         rel, rel_next;
  logic signed [SUM_BITS-1:0]  sum, sum_next;
  logic [PTR_BITS-1:0]         fin_link, fin_link_next;
  logic [DELAY_BITS-1:0]       fin_delay, fin_delay_next;
  cmd_t                        res_kind, res_kind_next;
  logic                        res_fired, res_fired_next;
  logic [ID_BITS-1:0]          res_fired_id, res_fired_id_next;
  logic signed [CD_BITS-1:0]   res_remaining, res_remaining_next;
  logic                        out_load;

  logic                        link_we;
  logic [ID_BITS-1:0]          link_waddr, link_raddr;
  logic [PTR_BITS-1:0]         link_wdata, link_rdata;
  logic                        delay_we;
  logic [ID_BITS-1:0]          delay_waddr, delay_raddr;
  logic [DELAY_BITS-1:0]       delay_wdata, delay_rdata;

  logic [DELAY_BITS-1:0]       d_sat;
  logic signed [CD_BITS-1:0]   d_ext;
  logic signed [REL_BITS-1:0]  rel_init;
  logic [REL_BITS-1:0]         head_gap;
  logic signed [SUM_BITS-1:0]  cd_ext, amt_ext, dly_ext, sum_add;
  logic                        head_nil, accept;

  dltq_ram #(.WIDTH(PTR_BITS), .DEPTH(TIMERS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  dltq_ram #(.WIDTH(DELAY_BITS), .DEPTH(TIMERS)) u_delay_ram (
    .clk   (clk),
    .we    (delay_we),
    .waddr (delay_waddr),
    .wdata (delay_wdata),
    .raddr (delay_raddr),
    .rdata (delay_rdata)
  );

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign head_nil = (head_ptr >= NIL);

  assign d_sat    = (AMT_BITS'(amount) > AMT_BITS'(DELAY_MAX)) ? DELAY_MAX
                                                                : DELAY_BITS'(amount);
  assign d_ext    = CD_BITS'(d_sat);
  assign rel_init = REL_BITS'(d_ext) - REL_BITS'(countdown);
  assign head_gap = REL_BITS'(countdown - d_ext);
  assign cd_ext   = SUM_BITS'(countdown);
  assign amt_ext  = SUM_BITS'(amount);
  assign dly_ext  = SUM_BITS'(delay_rdata);
  assign sum_add  = sum + dly_ext;

  always_comb begin
    state_next         = state;
    queued_next        = queued;
    head_next          = head_ptr;
    countdown_next     = countdown;
    tid_next           = tid;
    cur_next           = cur;
    nx_next            = nx;
    rel_next           = rel;
    sum_next           = sum;
    fin_link_next      = fin_link;
    fin_delay_next     = fin_delay;
    res_kind_next      = res_kind;
    res_fired_next     = res_fired;
    res_fired_id_next  = res_fired_id;
    res_remaining_next = res_remaining;
    out_load           = 1'b0;

    link_we     = 1'b0;
    link_waddr  = cur[ID_BITS-1:0];
    link_wdata  = {1'b0, tid};
    link_raddr  = head_ptr[ID_BITS-1:0];
    delay_we    = 1'b0;
    delay_waddr = head_ptr[ID_BITS-1:0];
    delay_wdata = fin_delay;
    delay_raddr = link_rdata[ID_BITS-1:0];

    case (state)
      ST_IDLE: begin
        if (accept) begin
          tid_next           = timer_id;
          res_kind_next      = cmd_t'(command);
          res_fired_next     = 1'b0;
          res_fired_id_next  = '0;
          res_remaining_next = '0;
          state_next         = ST_RES;
          case (cmd_t'(command))
            CMD_SCHEDULE: begin
              if (!queued[timer_id]) begin
                queued_next[timer_id] = 1'b1;
                if (head_nil) begin
                  link_we        = 1'b1;
                  link_waddr     = timer_id;
                  link_wdata     = NIL;
                  delay_we       = 1'b1;
                  delay_waddr    = timer_id;
                  delay_wdata    = d_sat;
                  head_next      = {1'b0, timer_id};
                  countdown_next = d_ext;
                end else if (countdown > d_ext) begin
                  delay_we       = 1'b1;
                  delay_waddr    = head_ptr[ID_BITS-1:0];
                  delay_wdata    = clamp_delay(head_gap);
                  countdown_next = d_ext;
                  head_next      = {1'b0, timer_id};
                  fin_link_next  = head_ptr;
                  fin_delay_next = d_sat;
                  state_next     = ST_S_FIN;
                end else begin
                  cur_next   = head_ptr;
                  rel_next   = REL_BITS'(rel_init);
                  state_next = ST_S_LINK;
                end
              end
            end
            CMD_QUERY: begin
              if (!queued[timer_id] || head_nil) begin
                res_remaining_next = NOT_QUEUED;
              end else if (head_ptr == {1'b0, timer_id}) begin
                res_remaining_next = countdown;
              end else begin
                sum_next   = cd_ext;
                state_next = ST_Q_LINK;
              end
            end
            CMD_FIRE: begin
              if (head_nil) begin
                countdown_next = CD_MAX;
              end else begin
                queued_next[head_ptr[ID_BITS-1:0]] = 1'b0;
                res_fired_next    = 1'b1;
                res_fired_id_next = head_ptr[ID_BITS-1:0];
                state_next        = ST_F_LINK;
              end
            end
            default: begin
              if (!head_nil) begin
                countdown_next = clamp_cd(cd_ext - amt_ext);
              end
            end
          endcase
        end
      end

      ST_S_LINK: begin
        if (link_rdata >= NIL) begin
          link_we        = 1'b1;
          link_waddr     = cur[ID_BITS-1:0];
          link_wdata     = {1'b0, tid};
          fin_link_next  = NIL;
          fin_delay_next = clamp_delay(rel);
          state_next     = ST_S_FIN;
        end else begin
          nx_next    = link_rdata;
          state_next = ST_S_DLY;
        end
      end

      ST_S_DLY: begin
        if (rel < REL_BITS'(delay_rdata)) begin
          delay_we       = 1'b1;
          delay_waddr    = nx[ID_BITS-1:0];
          delay_wdata    = delay_rdata - DELAY_BITS'(rel);
          link_we        = 1'b1;
          link_waddr     = cur[ID_BITS-1:0];
          link_wdata     = {1'b0, tid};
          fin_link_next  = nx;
          fin_delay_next = clamp_delay(rel);
          state_next     = ST_S_FIN;
        end else begin
          link_raddr = nx[ID_BITS-1:0];
          cur_next   = nx;
          rel_next   = rel - REL_BITS'(delay_rdata);
          state_next = ST_S_LINK;
        end
      end

      ST_S_FIN: begin
        link_we     = 1'b1;
        link_waddr  = tid;
        link_wdata  = fin_link;
        delay_we    = 1'b1;
        delay_waddr = tid;
        delay_wdata = fin_delay;
        state_next  = ST_RES;
      end

      ST_Q_LINK: begin
        cur_next   = link_rdata;
        state_next = ST_Q_DLY;
      end

      ST_Q_DLY: begin
        sum_next = sum_add;
        if (cur == {1'b0, tid}) begin
          res_remaining_next = clamp_cd(sum_add);
          state_next         = ST_RES;
        end else begin
          link_raddr = cur[ID_BITS-1:0];
          state_next = ST_Q_LINK;
        end
      end

      ST_F_LINK: begin
        head_next = link_rdata;
        if (link_rdata >= NIL) begin
          countdown_next = CD_MAX;
          state_next     = ST_RES;
        end else begin
          state_next = ST_F_DLY;
        end
      end

      ST_F_DLY: begin
        countdown_next = clamp_cd(cd_ext + dly_ext);
        state_next     = ST_RES;
      end

      ST_RES: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      queued    <= '0;
      head_ptr  <= NIL;
      countdown <= CD_MAX;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      queued    <= queued_next;
      head_ptr  <= head_next;
      countdown <= countdown_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tid           <= tid_next;
    cur           <= cur_next;
    nx            <= nx_next;
    rel           <= rel_next;
    sum           <= sum_next;
    fin_link      <= fin_link_next;
    fin_delay     <= fin_delay_next;
    res_kind      <= res_kind_next;
    res_fired     <= res_fired_next;
    res_fired_id  <= res_fired_id_next;
    res_remaining <= res_remaining_next;
    if (out_load) begin
      kind          <= res_kind;
      fired         <= res_fired;
      fired_id      <= res_fired_id;
      remaining     <= res_remaining;
      due           <= !head_nil && (countdown[CD_BITS-1] || (countdown == '0));
      countdown_now <= countdown;
    end
  end

  // an accepted transaction keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted again right after a transaction");

  // only a fire result can report a popped timer
  a_fired_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> kind == CMD_FIRE)
    else $error("fired flag on a non-fire result");

  // between commands the head timer is marked queued
  a_head_queued: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && !head_nil |-> queued[head_ptr[ID_BITS-1:0]])
    else $error("head timer not marked queued");

  // an empty list has no queued timer
  a_empty_none_queued: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && head_nil |-> queued == '0)
    else $error("queued timer with an empty list");

endmodule
`default_nettype wire
